// ----- sv/crd_pkg.sv -----
// ----------------------------------------------------------------------------
// crd_pkg
// Types, constants and the error-byte map for the reader response deframer.
// ----------------------------------------------------------------------------
package crd_pkg;

  localparam int MAX_MSG_BYTES = 512;
  localparam int POS_W         = $clog2(MAX_MSG_BYTES + 1);
  localparam int LEN_W         = 32;

  // header byte positions
  localparam logic [POS_W-1:0] POS_TYPE   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LEN0   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LEN1   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LEN2   = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LEN3   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_SLOT   = POS_W'(5);
  localparam logic [POS_W-1:0] POS_SEQ    = POS_W'(6);
  localparam logic [POS_W-1:0] POS_STATUS = POS_W'(7);
  localparam logic [POS_W-1:0] POS_ERROR  = POS_W'(8);
  localparam logic [POS_W-1:0] POS_RSVD   = POS_W'(9);
  localparam logic [POS_W-1:0] HDR_BYTES  = POS_W'(10);
  localparam logic [POS_W-1:0] POS_MAX    = POS_W'(MAX_MSG_BYTES);

  // command status field, bits 7:6 of the status byte
  localparam logic [1:0] CMD_OK        = 2'd0;
  localparam logic [1:0] CMD_MORE_TIME = 2'd2;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_GENERIC      = 4'd1,
    ST_NO_CARD      = 4'd2,
    ST_COMM         = 4'd3,
    ST_NO_ATR       = 4'd4,
    ST_INCOMPATIBLE = 4'd5,
    ST_INVALID_ARG  = 4'd6,
    ST_BUSY         = 4'd7,
    ST_USER_TIMEOUT = 4'd8,
    ST_USER_ABORT   = 4'd9,
    ST_UNSUPPORTED  = 4'd10,
    ST_BAD_SLOT     = 4'd11,
    ST_BUF_SMALL    = 4'd12,
    ST_WRONG_TYPE   = 4'd13
  } status_t;

  // reader error bytes
  localparam logic [7:0] ERR_NO_CARD    = 8'hFE;
  localparam logic [7:0] ERR_COMM_A     = 8'hFD;
  localparam logic [7:0] ERR_COMM_B     = 8'hFC;
  localparam logic [7:0] ERR_ATR_A      = 8'hF8;
  localparam logic [7:0] ERR_ATR_B      = 8'hF7;
  localparam logic [7:0] ERR_PROTO_A    = 8'hF6;
  localparam logic [7:0] ERR_PROTO_B    = 8'hF5;
  localparam logic [7:0] ERR_INV_ARG    = 8'hF4;
  localparam logic [7:0] ERR_BUSY_A     = 8'hF2;
  localparam logic [7:0] ERR_BUSY_B     = 8'hE0;
  localparam logic [7:0] ERR_TIMEOUT    = 8'hF0;
  localparam logic [7:0] ERR_ABORT      = 8'hEF;
  localparam logic [7:0] ERR_UNSUPP     = 8'h00;
  localparam logic [7:0] ERR_SLOT       = 8'h05;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        last_byte;
    logic [7:0]  expected_slot;
    logic [7:0]  expected_seq;
    logic [7:0]  expected_type;
    logic [15:0] out_capacity;
  } crd_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        done_res;
    logic [3:0]  status_code;
    logic [15:0] data_count;
  } crd_out_t;

  function automatic status_t map_error(input logic [7:0] e);
    status_t s;
    case (e)
      ERR_NO_CARD:              s = ST_NO_CARD;
      ERR_COMM_A, ERR_COMM_B:   s = ST_COMM;
      ERR_ATR_A, ERR_ATR_B:     s = ST_NO_ATR;
      ERR_PROTO_A, ERR_PROTO_B: s = ST_INCOMPATIBLE;
      ERR_INV_ARG:              s = ST_INVALID_ARG;
      ERR_BUSY_A, ERR_BUSY_B:   s = ST_BUSY;
      ERR_TIMEOUT:              s = ST_USER_TIMEOUT;
      ERR_ABORT:                s = ST_USER_ABORT;
      ERR_UNSUPP:               s = ST_UNSUPPORTED;
      ERR_SLOT:                 s = ST_BAD_SLOT;
      default:                  s = ST_GENERIC;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/ccid_response_deframer.sv -----
// ----------------------------------------------------------------------------
// ccid_response_deframer
// Parses reader response messages byte by byte, forwards payload, closes each
// exchange with a status code; more-time and foreign OK replies get none.
// ----------------------------------------------------------------------------
// Path: a byte is registered in the input reg, its result in the result reg.
// Throughput: one byte per cycle while the receiver does not stall; the
// header/payload decision is single pass.
// A byte waits in the input reg while a stalled result holds the result reg.
// Reset (rst, synchronous): clears position, header fields and both stages.
module ccid_response_deframer (
  input  logic             clk,
  input  logic             rst,
  input  logic             msg_valid,
  output logic             msg_stall,
  input  crd_pkg::crd_in_t  msg,
  output logic             res_valid,
  input  logic             res_stall,
  output crd_pkg::crd_out_t res
);
  import crd_pkg::*;

  logic     held_valid;
  crd_in_t  held;
  logic     free;
  logic     step;
  logic     has_res;
  crd_out_t parsed;

  assign step = held_valid && free;

  crd_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .held_valid(held_valid),
    .held      (held),
    .take      (step)
  );

  crd_parser u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (held),
    .has_res(has_res),
    .res    (parsed)
  );

  crd_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && has_res),
    .d        (parsed),
    .free     (free),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

endmodule

// ----- sv/crd_in_reg.sv -----
// ----------------------------------------------------------------------------
// crd_in_reg
// Input register stage; holds one item until the parser takes it.
// ----------------------------------------------------------------------------
module crd_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            msg_valid,
  output logic            msg_stall,
  input  crd_pkg::crd_in_t msg,
  output logic            held_valid,
  output crd_pkg::crd_in_t held,
  input  logic            take
);
  import crd_pkg::*;

  logic load;

  assign load      = !held_valid || take;
  assign msg_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= msg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && msg_valid) begin
      held <= msg;
    end
  end

endmodule

// ----- sv/crd_parser.sv -----
// ----------------------------------------------------------------------------
// crd_parser
// Header capture, payload forwarding and closing status for one byte.
// ----------------------------------------------------------------------------
module crd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  crd_pkg::crd_in_t  item,
  output logic             has_res,
  output crd_pkg::crd_out_t res
);
  import crd_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       hdr_type, hdr_type_next;
  logic [LEN_W-1:0] plen, plen_next;
  logic [7:0]       hdr_slot, hdr_slot_next;
  logic [7:0]       hdr_seq, hdr_seq_next;
  logic [7:0]       stat, stat_next;
  logic [7:0]       err, err_next;
  logic             fwd, fwd_next;

  logic             vld, done;
  logic [7:0]       ob;
  status_t          code;
  logic [15:0]      count;
  logic [1:0]       cmd;
  logic             match, type_ok;
  logic [LEN_W:0]   need;
  logic [POS_W-1:0] pay_idx;

  always_comb begin
    pos_next      = pos;
    hdr_type_next = hdr_type;
    plen_next     = plen;
    hdr_slot_next = hdr_slot;
    hdr_seq_next  = hdr_seq;
    stat_next     = stat;
    err_next      = err;
    fwd_next      = fwd;
    vld           = 1'b0;
    ob            = 8'd0;
    pay_idx       = pos - HDR_BYTES;

    if (pos < POS_MAX) begin
      case (pos)
        POS_TYPE: begin
          hdr_type_next = item.rx_byte;
          fwd_next      = 1'b0;
        end
        POS_LEN0:   plen_next        = {24'd0, item.rx_byte};
        POS_LEN1:   plen_next[15:8]  = item.rx_byte;
        POS_LEN2:   plen_next[23:16] = item.rx_byte;
        POS_LEN3:   plen_next[31:24] = item.rx_byte;
        POS_SLOT:   hdr_slot_next    = item.rx_byte;
        POS_SEQ:    hdr_seq_next     = item.rx_byte;
        POS_STATUS: stat_next        = item.rx_byte;
        POS_ERROR:  err_next         = item.rx_byte;
        POS_RSVD: begin
          fwd_next = (stat[7:6] == CMD_OK) && (hdr_slot == item.expected_slot) &&
                     (hdr_seq == item.expected_seq) &&
                     ((item.expected_type == 8'd0) || (hdr_type == item.expected_type)) &&
                     (plen != '0) && ({16'd0, item.out_capacity} >= plen);
        end
        default: begin
          if (fwd && ({{(LEN_W-POS_W){1'b0}}, pay_idx} < plen)) begin
            vld = 1'b1;
            ob  = item.rx_byte;
          end
        end
      endcase
      pos_next = pos + POS_W'(1);
    end

    // closing decision on the updated header
    cmd     = stat_next[7:6];
    match   = (hdr_slot_next == item.expected_slot) && (hdr_seq_next == item.expected_seq);
    type_ok = (item.expected_type == 8'd0) || (hdr_type_next == item.expected_type);
    need    = {1'b0, plen_next} + (LEN_W+1)'(HDR_BYTES);
    done    = 1'b0;
    code    = ST_OK;
    count   = 16'd0;

    if (item.last_byte) begin
      if (pos_next < POS_RSVD) begin
        done = 1'b1;
        code = ST_GENERIC;
      end else if (cmd == CMD_MORE_TIME) begin
        done = 1'b0;
      end else if (cmd != CMD_OK) begin
        done = 1'b1;
        code = map_error(err_next);
      end else if (!match) begin
        done = 1'b0;                    // foreign message, dropped
      end else if (!type_ok) begin
        done = 1'b1;
        code = ST_WRONG_TYPE;
      end else if (plen_next == '0) begin
        done = 1'b1;
      end else if ({{(LEN_W+1-POS_W){1'b0}}, pos_next} < need) begin
        done = 1'b1;
        code = ST_BUF_SMALL;            // truncated
      end else if ({16'd0, item.out_capacity} < plen_next) begin
        done = 1'b1;
        code = ST_BUF_SMALL;
      end else begin
        done  = 1'b1;
        count = plen_next[15:0];
      end
      pos_next = '0;
      fwd_next = 1'b0;
    end

    has_res         = vld || done;
    res.out_byte    = ob;
    res.byte_valid  = vld;
    res.done_res    = done;
    res.status_code = code;
    res.data_count  = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      hdr_type <= '0;
      plen     <= '0;
      hdr_slot <= '0;
      hdr_seq  <= '0;
      stat     <= '0;
      err      <= '0;
      fwd      <= 1'b0;
    end else if (step) begin
      pos      <= pos_next;
      hdr_type <= hdr_type_next;
      plen     <= plen_next;
      hdr_slot <= hdr_slot_next;
      hdr_seq  <= hdr_seq_next;
      stat     <= stat_next;
      err      <= err_next;
      fwd      <= fwd_next;
    end
  end

endmodule

// ----- sv/crd_out_reg.sv -----
// ----------------------------------------------------------------------------
// crd_out_reg
// Result register; loads a new item whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module crd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  crd_pkg::crd_out_t d,
  output logic             free,
  output logic             res_valid,
  input  logic             res_stall,
  output crd_pkg::crd_out_t res
);
  import crd_pkg::*;

  assign free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (free) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res <= d;
    end
  end

endmodule

// ----- sim/crd_response_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crd_response_checker
// Watches both channels of the response deframer, predicts the result of
// every accepted byte and compares each delivered result in order.
// ----------------------------------------------------------------------------
module crd_response_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  input  logic              msg_stall,
  input  crd_pkg::crd_in_t  msg,
  input  logic              res_valid,
  input  logic              res_stall,
  input  crd_pkg::crd_out_t res,
  output int                fail_count,
  output int                pending,
  output int                fwd_seen,
  output int                close_seen
);
  import crd_pkg::*;

  // parser state as the block should hold it
  logic [POS_W-1:0] pos;
  logic [7:0]       hdr_type;
  logic [31:0]      pay_len;
  logic [7:0]       hdr_slot;
  logic [7:0]       hdr_seq;
  logic [7:0]       stat_byte;
  logic [7:0]       err_byte;
  logic             fwd;

  status_t  err_map [256];
  crd_out_t pending_results [$];
  crd_out_t predicted;
  crd_out_t oldest;

  initial begin
    for (int i = 0; i < 256; i++) err_map[i] = ST_GENERIC;
    err_map[ERR_NO_CARD] = ST_NO_CARD;
    err_map[ERR_COMM_A]  = ST_COMM;
    err_map[ERR_COMM_B]  = ST_COMM;
    err_map[ERR_ATR_A]   = ST_NO_ATR;
    err_map[ERR_ATR_B]   = ST_NO_ATR;
    err_map[ERR_PROTO_A] = ST_INCOMPATIBLE;
    err_map[ERR_PROTO_B] = ST_INCOMPATIBLE;
    err_map[ERR_INV_ARG] = ST_INVALID_ARG;
    err_map[ERR_BUSY_A]  = ST_BUSY;
    err_map[ERR_BUSY_B]  = ST_BUSY;
    err_map[ERR_TIMEOUT] = ST_USER_TIMEOUT;
    err_map[ERR_ABORT]   = ST_USER_ABORT;
    err_map[ERR_UNSUPP]  = ST_UNSUPPORTED;
    err_map[ERR_SLOT]    = ST_BAD_SLOT;
  end

  // Advances the parser by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(input crd_in_t it, output crd_out_t r);
    logic [1:0] cmd;
    bit         closed;
    r      = '0;
    closed = 1'b0;
    if (pos < POS_MAX) begin
      case (pos)
        POS_TYPE: begin
          hdr_type = it.rx_byte;
          fwd      = 1'b0;
        end
        POS_LEN0:   pay_len = {24'd0, it.rx_byte};
        POS_LEN1:   pay_len[15:8] = it.rx_byte;
        POS_LEN2:   pay_len[23:16] = it.rx_byte;
        POS_LEN3:   pay_len[31:24] = it.rx_byte;
        POS_SLOT:   hdr_slot = it.rx_byte;
        POS_SEQ:    hdr_seq = it.rx_byte;
        POS_STATUS: stat_byte = it.rx_byte;
        POS_ERROR:  err_byte = it.rx_byte;
        POS_RSVD: begin
          fwd = (stat_byte[7:6] == CMD_OK) && (hdr_slot == it.expected_slot) &&
                (hdr_seq == it.expected_seq) &&
                (it.expected_type == 8'd0 || hdr_type == it.expected_type) &&
                (pay_len != 32'd0) && ({16'd0, it.out_capacity} >= pay_len);
        end
        default: begin
          // padding past the declared length is not forwarded
          if (fwd && (32'(pos) - 32'(HDR_BYTES)) < pay_len) begin
            r.byte_valid = 1'b1;
            r.out_byte   = it.rx_byte;
          end
        end
      endcase
      pos = pos + 1'b1;
    end
    if (it.last_byte) begin
      cmd    = stat_byte[7:6];
      closed = 1'b1;
      if (pos < POS_RSVD) begin
        r.status_code = ST_GENERIC;
      end else if (cmd == CMD_MORE_TIME) begin
        closed = 1'b0;
      end else if (cmd != CMD_OK) begin
        r.status_code = err_map[err_byte];
      end else if (hdr_slot != it.expected_slot || hdr_seq != it.expected_seq) begin
        closed = 1'b0;
      end else if (it.expected_type != 8'd0 && hdr_type != it.expected_type) begin
        r.status_code = ST_WRONG_TYPE;
      end else if (pay_len == 32'd0) begin
        r.status_code = ST_OK;
      end else if (33'(pos) < 33'(pay_len) + 33'(HDR_BYTES)) begin
        r.status_code = ST_BUF_SMALL;
      end else if ({16'd0, it.out_capacity} < pay_len) begin
        r.status_code = ST_BUF_SMALL;
      end else begin
        r.status_code = ST_OK;
        r.data_count  = pay_len[15:0];
      end
      r.done_res = closed;
      pos        = '0;
      fwd        = 1'b0;
    end
    return r.byte_valid || r.done_res;
  endfunction

  task automatic report_miss(input string why, input crd_out_t want,
                             input crd_out_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t mismatch, %s: expected byte=%02h bv=%0b done=%0b st=%0d cnt=%0d",
               $realtime, why, want.out_byte, want.byte_valid, want.done_res,
               want.status_code, want.data_count);
      $display("    got byte=%02h bv=%0b done=%0b st=%0d cnt=%0d",
               got.out_byte, got.byte_valid, got.done_res, got.status_code,
               got.data_count);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pos       = '0;
      hdr_type  = '0;
      pay_len   = '0;
      hdr_slot  = '0;
      hdr_seq   = '0;
      stat_byte = '0;
      err_byte  = '0;
      fwd       = 1'b0;
      pending_results.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_results.size() == 0) begin
          report_miss("no result due", '0, res);
        end else begin
          oldest = pending_results.pop_front();
          if (res.out_byte !== oldest.out_byte || res.byte_valid !== oldest.byte_valid ||
              res.done_res !== oldest.done_res || res.status_code !== oldest.status_code ||
              res.data_count !== oldest.data_count)
            report_miss("field differs", oldest, res);
          if (res.byte_valid === 1'b1) fwd_seen++;
          if (res.done_res === 1'b1) close_seen++;
        end
      end
      if (msg_valid && !msg_stall) begin
        if (parse_byte(msg, predicted)) pending_results.push_back(predicted);
      end
    end
    pending = pending_results.size();
  end

endmodule

// ----- sim/tb_ccid_response_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ccid_response_deframer
// Feeds reader response messages byte by byte into the deframer: directed
// header and status cases first, then random traffic with bursty input and
// a receiver that stalls, once for a long stretch. The checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ccid_response_deframer;
  import crd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_BYTES  = 300;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     msg_valid = 1'b0;
  logic     msg_stall;
  crd_in_t  msg       = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  crd_out_t res;
  logic     hold_req  = 1'b0;

  int fail_count;
  int pending;
  int fwd_seen;
  int close_seen;

  // fields held through the message being sent
  logic [7:0]  cur_slot;
  logic [7:0]  cur_seq;
  logic [7:0]  cur_type;
  logic [15:0] cur_cap;
  bit          jitter;
  logic [7:0]  frame_bytes [$];

  int       burst_left;
  int       msgs_sent;
  int       bytes_sent;
  int       cycle_count;
  rx_mode_t rx_mode = RX_FREE;
  int       hold_left;
  bit       hold_taken;

  always #10 clk = ~clk;

  ccid_response_deframer DUT (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  crd_response_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_stall  (msg_stall),
    .msg        (msg),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending),
    .fwd_seen   (fwd_seen),
    .close_seen (close_seen)
  );

  // receiver: random stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
      res_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 149) == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_FREE:  res_stall <= 1'b0;
        RX_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
        RX_HALF:  res_stall <= 1'($urandom_range(0, 1));
        default:  res_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("FAIL");
    $finish;
  end

  function automatic logic [7:0] err_pick(input int k);
    case (k)
      0:       return ERR_NO_CARD;
      1:       return ERR_COMM_A;
      2:       return ERR_COMM_B;
      3:       return ERR_ATR_A;
      4:       return ERR_ATR_B;
      5:       return ERR_PROTO_A;
      6:       return ERR_PROTO_B;
      7:       return ERR_INV_ARG;
      8:       return ERR_BUSY_A;
      9:       return ERR_BUSY_B;
      10:      return ERR_TIMEOUT;
      11:      return ERR_ABORT;
      12:      return ERR_UNSUPP;
      13:      return ERR_SLOT;
      default: return 8'h5C;  // not a reader error code
    endcase
  endfunction

  task automatic set_ctx(input logic [7:0] es, input logic [7:0] eq, input logic [7:0] et,
                         input logic [15:0] cap);
    cur_slot = es;
    cur_seq  = eq;
    cur_type = et;
    cur_cap  = cap;
    jitter   = 1'b0;
  endtask

  task automatic put_header(input logic [7:0] t, input logic [31:0] len, input logic [7:0] s,
                            input logic [7:0] q, input logic [7:0] st, input logic [7:0] er);
    frame_bytes.push_back(t);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[23:16]);
    frame_bytes.push_back(len[31:24]);
    frame_bytes.push_back(s);
    frame_bytes.push_back(q);
    frame_bytes.push_back(st);
    frame_bytes.push_back(er);
    frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic put_payload(input int n);
    repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // offers one item; returns at the edge where it was taken
  task automatic offer(input crd_in_t it);
    if (burst_left == 0) begin
      msg_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    msg       <= it;
    msg_valid <= 1'b1;
    do @(posedge clk); while (msg_stall);
  endtask

  task automatic send_frame();
    crd_in_t it;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      // occasionally the outstanding-command fields move mid-message
      if (jitter && $urandom_range(0, 3) == 0) begin
        cur_slot = 8'($urandom_range(0, 255));
        cur_seq  = 8'($urandom_range(0, 255));
        cur_type = 8'($urandom_range(0, 255));
        cur_cap  = 16'($urandom_range(0, 65535));
      end
      it.rx_byte       = frame_bytes[i];
      it.last_byte     = (i == frame_bytes.size() - 1);
      it.expected_slot = cur_slot;
      it.expected_seq  = cur_seq;
      it.expected_type = cur_type;
      it.out_capacity  = cur_cap;
      offer(it);
    end
    msgs_sent++;
    bytes_sent += frame_bytes.size();
    frame_bytes.delete();
  endtask

  // stop sending until every predicted result is out, then let the pipe empty
  task automatic drain();
    msg_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int          r;
    int          npay;
    int          rand_bytes;
    int          msg_idx;
    logic [31:0] len;
    logic [7:0]  h_type;
    logic [7:0]  h_slot;
    logic [7:0]  h_seq;
    logic [7:0]  h_stat;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // good message, capacity exactly the length, extreme payload bytes
    set_ctx(8'h03, 8'h11, 8'h80, 16'd4);
    put_header(8'h80, 32'd4, 8'h03, 8'h11, 8'h00, 8'h00);
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(8'hFF);
    frame_bytes.push_back(8'h5A);
    frame_bytes.push_back(8'hA5);
    send_frame();
    // empty payload with padding
    set_ctx(8'h03, 8'h12, 8'h80, 16'hFFFF);
    put_header(8'h80, 32'd0, 8'h03, 8'h12, 8'h00, 8'h00);
    put_payload(2);
    send_frame();
    // type check off, field extremes
    set_ctx(8'hFF, 8'h00, 8'h00, 16'd1);
    put_header(8'hFF, 32'd1, 8'hFF, 8'h00, 8'h3F, 8'hFF);
    frame_bytes.push_back(8'hFF);
    put_payload(1);
    send_frame();
    // wrong type
    set_ctx(8'h00, 8'hFF, 8'hFF, 16'hFFFF);
    put_header(8'h80, 32'd3, 8'h00, 8'hFF, 8'h00, 8'h00);
    put_payload(3);
    send_frame();
    // short messages, and one that stops right before the reserved byte
    put_payload(1);
    send_frame();
    put_payload(8);
    send_frame();
    set_ctx(8'h01, 8'h01, 8'h00, 16'd0);
    put_header(8'h81, 32'd0, 8'h01, 8'h01, 8'h00, 8'h00);
    void'(frame_bytes.pop_back());
    send_frame();
    // more time, foreign slot, foreign sequence: all dropped
    put_header(8'h80, 32'd2, 8'h01, 8'h01, 8'h80, 8'h00);
    put_payload(2);
    send_frame();
    put_header(8'h81, 32'd2, 8'h02, 8'h01, 8'h00, 8'h00);
    put_payload(2);
    send_frame();
    put_header(8'h81, 32'd2, 8'h01, 8'h02, 8'h00, 8'h00);
    put_payload(2);
    send_frame();
    // every error byte, both failure encodings, one with a foreign slot
    for (int k = 0; k < 15; k++) begin
      set_ctx(8'h07, 8'(k), 8'h80, 16'hFFFF);
      put_header(8'h80, 32'd0, (k == 3) ? 8'h09 : 8'h07, 8'(k), k[0] ? 8'h40 : 8'hFF,
                 err_pick(k));
      send_frame();
    end
    // truncated payload
    set_ctx(8'h05, 8'h06, 8'h00, 16'hFFFF);
    put_header(8'h80, 32'd8, 8'h05, 8'h06, 8'h00, 8'h00);
    put_payload(3);
    send_frame();
    // capacity one short
    set_ctx(8'h05, 8'h06, 8'h00, 16'd4);
    put_header(8'h80, 32'd5, 8'h05, 8'h06, 8'h00, 8'h00);
    put_payload(5);
    send_frame();
    // padding beyond the length
    set_ctx(8'h05, 8'h06, 8'h00, 16'd2);
    put_header(8'h80, 32'd2, 8'h05, 8'h06, 8'h00, 8'h00);
    put_payload(5);
    send_frame();
    // length with the top bytes set
    set_ctx(8'h05, 8'h06, 8'h00, 16'hFFFF);
    put_header(8'h80, 32'hFF00_0003, 8'h05, 8'h06, 8'h00, 8'h00);
    put_payload(3);
    send_frame();
    // zero capacity
    set_ctx(8'h05, 8'h06, 8'h00, 16'd0);
    put_header(8'h80, 32'd1, 8'h05, 8'h06, 8'h00, 8'h00);
    put_payload(1);
    send_frame();
    // overlong message runs past the byte limit
    set_ctx(8'h05, 8'h06, 8'h00, 16'hFFFF);
    put_header(8'h80, 32'd505, 8'h05, 8'h06, 8'h00, 8'h00);
    put_payload(505);
    send_frame();

    rand_bytes = 0;
    msg_idx    = 0;
    while (rand_bytes < RAND_BYTES) begin
      msg_idx++;
      if (msg_idx == 8) drain();
      set_ctx(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
              16'($urandom_range(0, 65535)));
      jitter = ($urandom_range(0, 19) == 0);
      if (msg_idx == 4) begin
        // long good payload while the receiver holds off
        hold_req <= 1'b1;
        jitter  = 1'b0;
        cur_cap = 16'hFFFF;
        put_header((cur_type == 8'h00) ? 8'h6B : cur_type, 32'd60, cur_slot, cur_seq,
                   8'h00, 8'h00);
        put_payload(60);
      end else if ($urandom_range(0, 99) < 6) begin
        put_payload($urandom_range(1, 9));
      end else begin
        if (cur_type == 8'h00 || $urandom_range(0, 6) == 0)
          h_type = 8'($urandom_range(0, 255));
        else
          h_type = cur_type;
        h_slot = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : cur_slot;
        h_seq  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : cur_seq;
        r = $urandom_range(0, 19);
        if (r < 13)      h_stat = {CMD_OK, 6'($urandom_range(0, 63))};
        else if (r < 15) h_stat = {CMD_MORE_TIME, 6'($urandom_range(0, 63))};
        else             h_stat = {($urandom_range(0, 1) == 0) ? 2'b01 : 2'b11,
                                   6'($urandom_range(0, 63))};
        r = $urandom_range(0, 19);
        if (r == 0)      len = 32'd0;
        else if (r < 16) len = $urandom_range(1, 8);
        else if (r < 19) len = $urandom_range(9, 40);
        else             len = $urandom();
        if (len > 32'd40) begin
          npay = $urandom_range(0, 16);
        end else begin
          r = $urandom_range(0, 19);
          if (r < 15)                   npay = len;
          else if (r < 17 && len != 0)  npay = $urandom_range(0, len - 1);
          else                          npay = len + $urandom_range(1, 4);
        end
        r = $urandom_range(0, 9);
        if (len > 32'd40)      cur_cap = 16'($urandom_range(0, 65535));
        else if (r < 4)        cur_cap = 16'(len) + 16'($urandom_range(0, 3));
        else if (r < 8)        cur_cap = 16'($urandom_range(len, 65535));
        else if (len != 32'd0) cur_cap = 16'($urandom_range(0, len - 1));
        put_header(h_type, len, h_slot, h_seq, h_stat,
                   ($urandom_range(0, 9) < 7) ? err_pick($urandom_range(0, 14))
                                              : 8'($urandom_range(0, 255)));
        put_payload(npay);
      end
      if (frame_bytes.size() < 64) rand_bytes += frame_bytes.size();
      send_frame();
    end
    drain();

    $display("Sent %0d messages (%0d bytes): header, status and length cases, then random",
             msgs_sent, bytes_sent);
    $display("traffic with bursty input and stalls; checked %0d payload bytes, %0d closings",
             fwd_seen, close_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
